/* sv/lu2x_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the 2x linear upsampler.
package lu2x_pkg;

  localparam int DEF_MAX_CHANNELS = 256;
  localparam int DEF_MAX_WIDTH    = 4096;

  localparam int SAMPLE_W  = 16;
  localparam int CHCFG_W   = 9;
  localparam int ROWCFG_W  = 13;
  localparam int CFG_W     = 13;
  localparam int OUTCOL_W  = 13;
  localparam int CHAN_W    = 8;

  // Register indexes of the write port.
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic REG_ROW_WIDTH     = 1'b1;

  // floor(t/3) == (t * RECIP3) >> RECIP3_SH for t < 2**19.
  localparam logic [17:0] RECIP3    = 18'd174763;
  localparam int          RECIP3_SH = 19;
  // 1 for rounding plus the bias that makes the sum non-negative.
  localparam logic [17:0] SUM_BIAS  = 18'd98305;

  // Which result of the current request is being produced.
  typedef enum logic [1:0] {
    STEP_RIGHT,  // right output of the previous column
    STEP_LEFT,   // left output of this column
    STEP_EDGE    // right output of the last column of a row
  } step_t;

endpackage

/* sv/linear_upsample_2x_1d.sv */
`timescale 1ns / 1ps
// Top level: 2x linear upsampler over channel-interleaved rows.
// Flow: the first result of a request passes from the work stage into the output
//   register; its other results follow one a cycle unless the output stalls.
// Throughput: one result per cycle unless the output stalls; a request yields 1 to 3
//   results (2 on average over a row); the single output register sets this rate.
// Reset: counters cleared, channel_count and row_width set to 1, pipeline emptied.
module linear_upsample_2x_1d
  import lu2x_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration write port
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // input requests
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  // result requests
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] value,
  output logic [OUTCOL_W-1:0]        out_column,
  output logic [CHAN_W-1:0]          channel,
  output logic                       last_of_run
);

  // Counter widths: index widths for the counters, and widths that can hold
  // the effective counts themselves.
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CCW = $clog2(MAX_CHANNELS + 1);
  localparam int WCW = $clog2(MAX_WIDTH + 1);

  // ---------------------------------------------------------------------
  // Configuration and effective (clamped) counts
  // ---------------------------------------------------------------------
  logic [CHCFG_W-1:0]  chan_cfg;
  logic [ROWCFG_W-1:0] row_cfg;
  logic [CCW-1:0]      chans_eff;
  logic [WCW-1:0]      width_eff;

  always_comb begin
    if (chan_cfg == '0) begin
      chans_eff = CCW'(1);
    end else if (32'(chan_cfg) > 32'(MAX_CHANNELS)) begin
      chans_eff = CCW'(MAX_CHANNELS);
    end else begin
      chans_eff = CCW'(chan_cfg);
    end
    if (row_cfg == '0) begin
      width_eff = WCW'(1);
    end else if (32'(row_cfg) > 32'(MAX_WIDTH)) begin
      width_eff = WCW'(MAX_WIDTH);
    end else begin
      width_eff = WCW'(row_cfg);
    end
  end

  // ---------------------------------------------------------------------
  // Position counters; a register write clears them, else they advance on every accepted request
  // ---------------------------------------------------------------------
  logic           in_fire;
  logic [CHW-1:0] ch_cnt;
  logic [CW-1:0]  col_cnt;
  logic           ch_wrap;
  logic           col_last;

  assign in_fire  = in_valid && in_ready;
  assign ch_wrap  = ((CCW + 1)'(ch_cnt) + (CCW + 1)'(1)) >= (CCW + 1)'(chans_eff);
  assign col_last = ((WCW + 1)'(col_cnt) + (WCW + 1)'(1)) >= (WCW + 1)'(width_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_cfg <= CHCFG_W'(1);
      row_cfg  <= ROWCFG_W'(1);
      ch_cnt   <= '0;
      col_cnt  <= '0;
    end else if (cfg_we) begin
      // any register write restarts the row at channel 0
      case (cfg_index)
        REG_CHANNEL_COUNT: chan_cfg <= cfg_data[CHCFG_W-1:0];
        REG_ROW_WIDTH:     row_cfg  <= cfg_data[ROWCFG_W-1:0];
        default:           row_cfg  <= row_cfg;
      endcase
      ch_cnt  <= '0;
      col_cnt <= '0;
    end else if (in_fire) begin
      if (ch_wrap) begin
        ch_cnt  <= '0;
        col_cnt <= col_last ? '0 : col_cnt + CW'(1);
      end else begin
        ch_cnt <= ch_cnt + CHW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Previous-column memory: one sample per channel, not cleared at reset
  // (every entry is written before its read value is used in a row). Read and write
  // share the accept edge; the read returns the old entry, so a following
  // request on the same channel already sees the new one and no forwarding
  // is needed.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] prev_mem [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0] prev_rd;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      prev_rd          <= prev_mem[ch_cnt];
      prev_mem[ch_cnt] <= sample;
    end
  end

  // ---------------------------------------------------------------------
  // Work stage: holds the request while its results are produced
  // ---------------------------------------------------------------------
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [CHW-1:0]             s1_ch;
  logic [CW-1:0]              s1_col;
  logic                       s1_last;
  step_t                      s1_step;

  logic                       emit;
  logic                       emit_final;
  step_t                      step_after;
  logic signed [SAMPLE_W-1:0] centre;
  logic signed [SAMPLE_W-1:0] side;
  logic [CW:0]                oc_wide;
  logic [17:0]                sum_biased;
  logic [35:0]                prod;
  logic [15:0]                quot;
  logic signed [SAMPLE_W-1:0] third_val;

  always_comb begin
    case (s1_step)
      STEP_RIGHT: begin
        centre     = prev_rd;
        side       = s1_x;
        oc_wide    = {s1_col - CW'(1), 1'b1};
        emit_final = 1'b0;
        step_after = STEP_LEFT;
      end
      STEP_LEFT: begin
        centre     = s1_x;
        side       = (s1_col == '0) ? s1_x : prev_rd;  // clamp at row start
        oc_wide    = {s1_col, 1'b0};
        emit_final = !s1_last;
        step_after = STEP_EDGE;
      end
      STEP_EDGE: begin
        centre     = s1_x;
        side       = s1_x;
        oc_wide    = {s1_col, 1'b1};
        emit_final = 1'b1;
        step_after = STEP_EDGE;
      end
      default: begin
        centre     = s1_x;
        side       = s1_x;
        oc_wide    = {s1_col, 1'b1};
        emit_final = 1'b1;
        step_after = STEP_EDGE;
      end
    endcase
  end

  // (2*centre + side + 1) / 3 rounded down, by reciprocal multiply on a
  // biased, non-negative sum; the result lands back in signed 16 bits.
  assign sum_biased = {centre[15], centre, 1'b0} + {{2{side[15]}}, side} + SUM_BIAS;
  assign prod       = 36'(sum_biased) * 36'(RECIP3);
  assign quot       = prod[RECIP3_SH+15:RECIP3_SH];
  assign third_val  = {~quot[15], quot[14:0]};

  assign emit     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || (emit && emit_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (emit && emit_final) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x    <= sample;
      s1_ch   <= ch_cnt;
      s1_col  <= col_cnt;
      s1_last <= col_last;
      s1_step <= (col_cnt == '0) ? STEP_LEFT : STEP_RIGHT;
    end else if (emit) begin
      s1_step <= step_after;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value       <= third_val;
      out_column  <= OUTCOL_W'(oc_wide);
      channel     <= CHAN_W'(s1_ch);
      last_of_run <= emit_final;
    end
  end

`ifndef SYNTHESIS
  // the edge output is only made for the last column of a row
  a_edge_only_last: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_step == STEP_EDGE |-> s1_last)
    else $error("edge output on a column that is not last");

  // the previous column's right output never comes from column 0
  a_right_not_first: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_step == STEP_RIGHT |-> s1_col != '0)
    else $error("right output of previous column at row start");

  // results of one request follow without a gap
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("gap inside a run of results");

  // within a request, columns ascend by one on the same channel
  a_run_columns: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=>
      out_column == $past(out_column) + OUTCOL_W'(1) && channel == $past(channel))
    else $error("result columns out of order within a run");
`endif

endmodule
